// File: hw/rtl/sacl_pkg.sv
// Shared types and constants for the set-associative LRU cache model.
package sacl_pkg;

  localparam int DEF_MAX_SET_BITS = 6;
  localparam int DEF_MAX_WAYS     = 8;

  localparam int ACTION_W = 2;
  localparam int ADDR_W   = 64;
  localparam int TAG_W    = 64;
  localparam int CNT_W    = 32;
  localparam int RANK_W   = 3;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD   = 2'd0,
    ACT_STORE  = 2'd1,
    ACT_MODIFY = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    REG_SET_BITS   = 2'd0,
    REG_BLOCK_BITS = 2'd1,
    REG_WAYS       = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

endpackage

// File: hw/rtl/sacl_intf.sv
// Request and response channel interfaces of the cache model.
interface sacl_req_if import sacl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [ADDR_W-1:0]   address;

  modport source (output valid, output action, output address, input ready);
  modport sink (input valid, input action, input address, output ready);
endinterface

interface sacl_rsp_if import sacl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       outcome;
  logic             second_hit;
  logic [CNT_W-1:0] hit_total;
  logic [CNT_W-1:0] miss_total;
  logic [CNT_W-1:0] eviction_total;

  modport source (output valid, output outcome, output second_hit, output hit_total,
                  output miss_total, output eviction_total, input ready);
  modport sink (input valid, input outcome, input second_hit, input hit_total,
                input miss_total, input eviction_total, output ready);
endinterface

// File: hw/rtl/set_assoc_cache_lru_sim.sv
// Top level of the set-associative cache model with exact LRU replacement.

// Each request splits its address into offset, set and tag, looks the set up and reports
// hit, fill or eviction along with saturating hit, miss and eviction totals. One tag
// comparator walks the ways of the set one per cycle, with ways_in_use taken as 1 when
// zero and capped at MAX_WAYS. The set's valid and age row and the first tag are read at
// the accepting edge. Then each way in use passes through the comparator, and the update
// state writes back ranks and tag. The sequencer then returns to idle, so a request is
// taken only once the previous one is written back. A new request is taken in the idle
// state even while the previous result still waits in the output register; its write-back
// then holds until that result is taken. After reset the valid and age memory is cleared
// one set per cycle, and no request is taken until the clear is done.
module set_assoc_cache_lru_sim import sacl_pkg::*; #(
  parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = DEF_MAX_WAYS
) (
  input  logic              clk,
  input  logic              rst,
  sacl_req_if.sink          req,
  sacl_rsp_if.source        rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  // Configuration registers.
  logic [2:0] set_bits;
  logic [5:0] block_bits;
  logic [3:0] ways_in_use;

  // Valid and age memories, one row per set; tag memory, one entry per line.
  logic [MAX_WAYS-1:0]             valid_mem [NUM_SETS];
  logic [MAX_WAYS-1:0][RANK_W-1:0] rank_mem  [NUM_SETS];
  logic [TAG_W-1:0]                tag_mem   [NUM_SETS][MAX_WAYS];

  state_t state, state_next;
  logic [SET_W-1:0] clr_idx;

  logic [SET_W-1:0]                set_q;
  logic [TAG_W-1:0]                tag_q;
  logic [WAY_W-1:0]                last_way_q;
  logic                            modify_q;
  logic [MAX_WAYS-1:0]             valid_rd;
  logic [MAX_WAYS-1:0][RANK_W-1:0] rank_rd;
  logic [TAG_W-1:0]                tag_rd;

  logic [WAY_W-1:0]  scan_way;
  logic              hit_found;
  logic              empty_found;
  logic [WAY_W-1:0]  hit_way;
  logic [WAY_W-1:0]  empty_way;
  logic [WAY_W-1:0]  victim_way;
  logic [RANK_W-1:0] best_rank;

  logic [CNT_W-1:0] hit_count, miss_count, eviction_count;
  logic [CNT_W-1:0] hit_count_next, miss_count_next, eviction_count_next;

  logic             rsp_valid;
  outcome_t         outcome_q;
  logic             second_hit_q;

  // Handshake and sequencer controls.
  logic accept, scan_en, upd_fire, clr_en, in_ready;

  // Address split of the incoming request.
  logic [3:0]       sb;
  logic [6:0]       tag_shamt;
  logic [ADDR_W-1:0] off_shifted;
  logic [SET_W-1:0] set_mask;
  logic [SET_W-1:0] set_now;
  logic [TAG_W-1:0] tag_now;
  logic [4:0]       ways_clamp;
  logic [WAY_W-1:0] last_way_now;

  // Read address of the tag memory.
  logic [SET_W-1:0] tag_rset;
  logic [WAY_W-1:0] tag_rway;

  // Comparator lane of the current way.
  logic              cur_valid;
  logic [RANK_W-1:0] cur_rank;
  logic              tag_eq;

  // Write-back values.
  outcome_t                        outcome_now;
  logic [WAY_W-1:0]                tgt_way;
  logic [RANK_W:0]                 old_rank;
  logic [MAX_WAYS-1:0]             way_in_use;
  logic [MAX_WAYS-1:0]             valid_new;
  logic [MAX_WAYS-1:0][RANK_W-1:0] rank_new;
  logic [1:0]                      hit_inc;
  logic [CNT_W:0]                  hit_sum, miss_sum, evict_sum;

  reg_idx_t cfg_idx;
  logic     cfg_wr;

  // ---------------------------------------------------------------------------
  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= 3'd0;
      block_bits  <= 6'd0;
      ways_in_use <= 4'd1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SET_BITS:   set_bits    <= pwdata[2:0];
        REG_BLOCK_BITS: block_bits  <= pwdata[5:0];
        REG_WAYS:       ways_in_use <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SET_BITS:   prdata = APB_DW'(set_bits);
      REG_BLOCK_BITS: prdata = APB_DW'(block_bits);
      REG_WAYS:       prdata = APB_DW'(ways_in_use);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Address split and way clamp.
  always_comb begin
    sb = (4'(set_bits) > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : 4'(set_bits);
    tag_shamt   = 7'(block_bits) + 7'(sb);
    off_shifted = req.address >> block_bits;
    tag_now     = tag_shamt[6] ? '0 : (req.address >> tag_shamt[5:0]);
    for (int j = 0; j < SET_W; j++) begin
      set_mask[j] = (4'(j) < sb);
    end
    set_now = off_shifted[SET_W-1:0] & set_mask;
    if (ways_in_use == 4'd0) begin
      ways_clamp = 5'd1;
    end else if (5'(ways_in_use) > 5'(MAX_WAYS)) begin
      ways_clamp = 5'(MAX_WAYS);
    end else begin
      ways_clamp = 5'(ways_in_use);
    end
    last_way_now = WAY_W'(ways_clamp - 5'd1);
  end

  // ---------------------------------------------------------------------------
  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_idx == SET_W'(NUM_SETS - 1)) state_next = ST_IDLE;
      ST_IDLE:   if (req.valid) state_next = ST_SCAN;
      ST_SCAN:   if (scan_way == last_way_q) state_next = ST_UPDATE;
      ST_UPDATE: if (!rsp_valid || rsp.ready) state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    scan_en  = 1'b0;
    upd_fire = 1'b0;
    clr_en   = 1'b0;
    unique case (state)
      ST_CLEAR:  clr_en   = 1'b1;
      ST_IDLE:   in_ready = 1'b1;
      ST_SCAN:   scan_en  = 1'b1;
      ST_UPDATE: upd_fire = !rsp_valid || rsp.ready;
    endcase
  end

  assign req.ready = in_ready;
  assign accept    = req.valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (clr_en) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Request capture and row read.
  always_ff @(posedge clk) begin
    if (accept) begin
      set_q      <= set_now;
      tag_q      <= tag_now;
      last_way_q <= last_way_now;
      modify_q   <= (action_t'(req.action) == ACT_MODIFY);
      valid_rd   <= valid_mem[set_now];
      rank_rd    <= rank_mem[set_now];
    end
  end

  // The tag of the next way is fetched while the current one is compared.
  always_comb begin
    if (state == ST_IDLE) begin
      tag_rset = set_now;
      tag_rway = '0;
    end else begin
      tag_rset = set_q;
      tag_rway = (scan_way == last_way_q) ? scan_way : scan_way + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    tag_rd <= tag_mem[tag_rset][tag_rway];
  end

  // ---------------------------------------------------------------------------
  // Way scan through the shared comparator.
  assign cur_valid = valid_rd[scan_way];
  assign cur_rank  = rank_rd[scan_way];
  assign tag_eq    = (tag_rd == tag_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_way    <= '0;
      hit_found   <= 1'b0;
      empty_found <= 1'b0;
    end else if (accept) begin
      scan_way    <= '0;
      hit_found   <= 1'b0;
      empty_found <= 1'b0;
    end else if (scan_en) begin
      if (cur_valid && tag_eq && !hit_found) begin
        hit_found <= 1'b1;
        hit_way   <= scan_way;
      end
      if (!cur_valid) begin
        empty_found <= 1'b1;
        empty_way   <= scan_way;
      end
      // Strictly older wins, so ties stay with the lowest way.
      if (scan_way == '0 || cur_rank > best_rank) begin
        best_rank  <= cur_rank;
        victim_way <= scan_way;
      end
      if (scan_way != last_way_q) begin
        scan_way <= scan_way + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Write-back: rank update, tag fill and counters.
  always_comb begin
    if (hit_found) begin
      outcome_now = OUT_HIT;
      tgt_way     = hit_way;
      old_rank    = {1'b0, rank_rd[hit_way]};
    end else if (empty_found) begin
      outcome_now = OUT_FILL;
      tgt_way     = empty_way;
      old_rank    = {1'b1, {RANK_W{1'b0}}};
    end else begin
      outcome_now = OUT_EVICT;
      tgt_way     = victim_way;
      old_rank    = {1'b0, best_rank};
    end

    for (int i = 0; i < MAX_WAYS; i++) begin
      way_in_use[i] = (WAY_W'(i) <= last_way_q);
      valid_new[i]  = valid_rd[i] || (WAY_W'(i) == tgt_way);
      rank_new[i]   = rank_rd[i];
      if (WAY_W'(i) == tgt_way) begin
        rank_new[i] = '0;
      end else if (way_in_use[i] && valid_rd[i] && ({1'b0, rank_rd[i]} < old_rank)
                   && (rank_rd[i] != RANK_MAX)) begin
        rank_new[i] = rank_rd[i] + 1'b1;
      end
    end

    hit_inc   = 2'(outcome_now == OUT_HIT) + 2'(modify_q);
    hit_sum   = {1'b0, hit_count} + (CNT_W + 1)'(hit_inc);
    miss_sum  = {1'b0, miss_count} + (CNT_W + 1)'(outcome_now != OUT_HIT);
    evict_sum = {1'b0, eviction_count} + (CNT_W + 1)'(outcome_now == OUT_EVICT);
    hit_count_next      = hit_sum[CNT_W]   ? '1 : hit_sum[CNT_W-1:0];
    miss_count_next     = miss_sum[CNT_W]  ? '1 : miss_sum[CNT_W-1:0];
    eviction_count_next = evict_sum[CNT_W] ? '1 : evict_sum[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (clr_en) begin
      valid_mem[clr_idx] <= '0;
      rank_mem[clr_idx]  <= '0;
    end else if (upd_fire) begin
      valid_mem[set_q] <= valid_new;
      rank_mem[set_q]  <= rank_new;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire && outcome_now != OUT_HIT) begin
      tag_mem[set_q][tgt_way] <= tag_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_count      <= '0;
      miss_count     <= '0;
      eviction_count <= '0;
    end else if (upd_fire) begin
      hit_count      <= hit_count_next;
      miss_count     <= miss_count_next;
      eviction_count <= eviction_count_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register. Totals stay put while a result waits, since no write-back
  // happens until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (upd_fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      outcome_q    <= outcome_now;
      second_hit_q <= modify_q;
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.outcome        = outcome_q;
  assign rsp.second_hit     = second_hit_q;
  assign rsp.hit_total      = hit_count;
  assign rsp.miss_total     = miss_count;
  assign rsp.eviction_total = eviction_count;

`ifndef SYNTH
  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == ST_SCAN))
    else $error("accepted request did not start the way scan");

  a_result_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == ST_UPDATE))
    else $error("result appeared without a write-back");

  a_evict_only_full: assert property (@(posedge clk) disable iff (rst)
    (upd_fire && outcome_now == OUT_EVICT) |-> ((valid_rd & way_in_use) == way_in_use))
    else $error("eviction chosen while a way in use was empty");
`endif

endmodule

// File: dv/set_assoc_cache_lru_sim_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the set-associative LRU cache model with its own cache predictor.
module set_assoc_cache_lru_sim_test;
  import sacl_pkg::*;

  localparam int MAX_SET     = DEF_MAX_SET_BITS;
  localparam int MAX_W       = DEF_MAX_WAYS;
  localparam int NUM_LINES   = (1 << MAX_SET) * MAX_W;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 12;

  typedef struct {
    logic [ACTION_W-1:0] action;
    logic [ADDR_W-1:0]   address;
  } access_t;

  typedef struct {
    outcome_t         outcome;
    logic             second_hit;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] evictions;
  } cache_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  sacl_req_if req_ch ();
  sacl_rsp_if rsp_ch ();

  set_assoc_cache_lru_sim dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  // Predictor copy of the configuration and the cache contents.
  logic [2:0]       cfg_set_bits = 3'd0;
  logic [5:0]       cfg_block_bits = 6'd0;
  logic [3:0]       cfg_ways = 4'd1;
  logic             line_valid [NUM_LINES];
  logic [TAG_W-1:0] line_tag [NUM_LINES];
  logic [RANK_W-1:0] line_rank [NUM_LINES];
  logic [CNT_W-1:0] hit_count = '0;
  logic [CNT_W-1:0] miss_count = '0;
  logic [CNT_W-1:0] eviction_count = '0;

  access_t       pending_requests [$];
  cache_result_t expected_results [$];

  int  req_gap = 0;
  int  rsp_hold = 0;
  bit  calm_mode = 1'b0;
  int  mismatches = 0;
  int  results_checked = 0;
  int  outcome_seen [3] = '{0, 0, 0};
  int  config_writes = 0;
  int  cycle_count = 0;

  initial begin
    for (int i = 0; i < NUM_LINES; i++) begin
      line_valid[i] = 1'b0;
      line_tag[i]   = '0;
      line_rank[i]  = '0;
    end
  end

  // Way w becomes the most recent; valid ways younger than its old rank age by one.
  function automatic void age_set(int base, int ways, int w, int old_rank);
    for (int i = 0; i < ways; i++) begin
      if (i != w && line_valid[base + i] && line_rank[base + i] < old_rank &&
          line_rank[base + i] < RANK_MAX)
        line_rank[base + i] = line_rank[base + i] + 1'b1;
    end
    line_rank[base + w] = '0;
  endfunction

  function automatic cache_result_t cache_access(logic [ACTION_W-1:0] act,
                                                 logic [ADDR_W-1:0] addr);
    cache_result_t    res;
    int               sb;
    int               ways;
    int               base;
    int               hit_way;
    int               empty_way;
    int               victim;
    int               shift_t;
    logic [TAG_W-1:0] tag;
    logic [ADDR_W-1:0] set_field;
    sb = (cfg_set_bits > MAX_SET) ? MAX_SET : int'(cfg_set_bits);
    ways = (cfg_ways == 0) ? 1 : ((cfg_ways > MAX_W) ? MAX_W : int'(cfg_ways));
    shift_t = int'(cfg_block_bits) + sb;
    tag = (shift_t >= 64) ? '0 : (addr >> shift_t);
    set_field = addr >> cfg_block_bits;
    base = int'(set_field & ((64'd1 << sb) - 1)) * MAX_W;
    hit_way = -1;
    empty_way = -1;
    for (int i = 0; i < ways; i++) begin
      if (line_valid[base + i]) begin
        if (hit_way < 0 && line_tag[base + i] == tag) hit_way = i;
      end else begin
        empty_way = i;
      end
    end
    if (hit_way >= 0) begin
      age_set(base, ways, hit_way, int'(line_rank[base + hit_way]));
      if (hit_count != '1) hit_count++;
      res.outcome = OUT_HIT;
    end else if (empty_way >= 0) begin
      line_valid[base + empty_way] = 1'b1;
      line_tag[base + empty_way]   = tag;
      age_set(base, ways, empty_way, int'(RANK_MAX) + 1);
      if (miss_count != '1) miss_count++;
      res.outcome = OUT_FILL;
    end else begin
      // Oldest way loses; among equal ranks the lowest way number is kept as victim.
      victim = 0;
      for (int i = 1; i < ways; i++)
        if (line_rank[base + i] > line_rank[base + victim]) victim = i;
      line_tag[base + victim] = tag;
      age_set(base, ways, victim, int'(line_rank[base + victim]));
      if (miss_count != '1) miss_count++;
      if (eviction_count != '1) eviction_count++;
      res.outcome = OUT_EVICT;
    end
    res.second_hit = (act == ACT_MODIFY);
    if (res.second_hit && hit_count != '1) hit_count++;
    res.hits      = hit_count;
    res.misses    = miss_count;
    res.evictions = eviction_count;
    return res;
  endfunction

  function automatic void note_mismatch(string field, logic [63:0] want, logic [63:0] got);
    if (mismatches < 10)
      $display("[%0t] %s mismatch: expected %0h, got %0h", $realtime, field, want, got);
    mismatches++;
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [APB_DW-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SET_BITS:   cfg_set_bits = value[2:0];
      REG_BLOCK_BITS: cfg_block_bits = value[5:0];
      default:        cfg_ways = value[3:0];
    endcase
    config_writes++;
  endtask

  // Polled on the falling edge so the driver and checker have settled.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_requests.size() != 0 || req_ch.valid || expected_results.size() != 0);
  endtask

  // Request driver: a new request goes out once the previous one is taken.
  always @(posedge clk) begin
    access_t next_access;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready)
        expected_results.push_back(cache_access(req_ch.action, req_ch.address));
      if (!req_ch.valid || req_ch.ready) begin
        if (req_gap == 0 && !calm_mode && $urandom_range(0, 15) == 0)
          req_gap = $urandom_range(1, 12);
        if (req_gap > 0 || pending_requests.size() == 0) begin
          if (req_gap > 0) req_gap--;
          req_ch.valid <= 1'b0;
        end else begin
          next_access = pending_requests.pop_front();
          req_ch.valid   <= 1'b1;
          req_ch.action  <= next_access.action;
          req_ch.address <= next_access.address;
        end
      end
    end
  end

  // Response checker with random backpressure.
  always @(posedge clk) begin
    cache_result_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_results.size() == 0) begin
          note_mismatch("unexpected result, outcome", '1, rsp_ch.outcome);
        end else begin
          want = expected_results.pop_front();
          if (rsp_ch.outcome !== want.outcome)
            note_mismatch("outcome", want.outcome, rsp_ch.outcome);
          if (rsp_ch.second_hit !== want.second_hit)
            note_mismatch("second_hit", want.second_hit, rsp_ch.second_hit);
          if (rsp_ch.hit_total !== want.hits)
            note_mismatch("hit_total", want.hits, rsp_ch.hit_total);
          if (rsp_ch.miss_total !== want.misses)
            note_mismatch("miss_total", want.misses, rsp_ch.miss_total);
          if (rsp_ch.eviction_total !== want.evictions)
            note_mismatch("eviction_total", want.evictions, rsp_ch.eviction_total);
          if (want.outcome <= OUT_EVICT) outcome_seen[want.outcome]++;
          results_checked++;
        end
      end
      if (rsp_hold == 0 && !calm_mode && $urandom_range(0, 15) == 0)
        rsp_hold = $urandom_range(1, 12);
      if (rsp_hold > 0) begin
        rsp_hold--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int               set_cfg;
    int               block_cfg;
    int               ways_cfg;
    int               sb_eff;
    int               ways_eff;
    int               shift_t;
    int               set_pick;
    int               item_count;
    logic [ADDR_W-1:0] addr;
    logic [TAG_W-1:0] tag_pool [$];
    access_t          acc;

    req_ch.valid   = 1'b0;
    req_ch.action  = '0;
    req_ch.address = '0;
    rsp_ch.ready   = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        case (phase)
          1:       begin set_cfg = 2; block_cfg = 4;  ways_cfg = 4;  end
          2:       begin set_cfg = 6; block_cfg = 6;  ways_cfg = 8;  end
          3:       begin set_cfg = 7; block_cfg = 63; ways_cfg = 15; end
          4:       begin set_cfg = 0; block_cfg = 0;  ways_cfg = 0;  end
          5:       begin set_cfg = 5; block_cfg = 62; ways_cfg = 5;  end
          6:       begin set_cfg = 3; block_cfg = 32; ways_cfg = 2;  end
          7:       begin set_cfg = 1; block_cfg = 58; ways_cfg = 3;  end
          11:      begin set_cfg = 4; block_cfg = 5;  ways_cfg = 8;  end
          default: begin
            set_cfg   = $urandom_range(0, 7);
            block_cfg = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                    : $urandom_range(0, 12);
            ways_cfg  = $urandom_range(0, 15);
          end
        endcase
        // Upper bits of the write data are sometimes junk; the registers keep only their width.
        write_reg(REG_SET_BITS, ($urandom_range(0, 3) == 0) ?
                  (32'(set_cfg) | ($urandom << 3)) : 32'(set_cfg));
        write_reg(REG_BLOCK_BITS, ($urandom_range(0, 3) == 0) ?
                  (32'(block_cfg) | ($urandom << 6)) : 32'(block_cfg));
        write_reg(REG_WAYS, ($urandom_range(0, 3) == 0) ?
                  (32'(ways_cfg) | ($urandom << 4)) : 32'(ways_cfg));
      end
      if (phase == PHASES - 1) calm_mode = 1'b1;

      if (phase == 0) begin
        // One set, one way, the whole address is the tag.
        pending_requests.push_back('{ACT_LOAD, 64'h0});
        pending_requests.push_back('{ACT_LOAD, 64'h0});
        pending_requests.push_back('{ACT_STORE, '1});
        pending_requests.push_back('{ACT_MODIFY, '1});
        pending_requests.push_back('{2'(3), 64'h0});
        pending_requests.push_back('{ACT_MODIFY, 64'h8000_0000_0000_0000});
        pending_requests.push_back('{ACT_STORE, 64'h8000_0000_0000_0000});
        pending_requests.push_back('{ACT_LOAD, 64'h5555_5555_5555_5555});
        pending_requests.push_back('{ACT_MODIFY, 64'hAAAA_AAAA_AAAA_AAAA});
      end else if (phase == 2) begin
        // Ten tags into set 0 of an eight-way set: fills, then LRU evictions.
        for (int k = 0; k < 10; k++)
          pending_requests.push_back('{ACT_LOAD, 64'(k) << 12});
        pending_requests.push_back('{ACT_LOAD, 64'h0});
        pending_requests.push_back('{ACT_MODIFY, 64'(9) << 12});
      end

      sb_eff   = (cfg_set_bits > MAX_SET) ? MAX_SET : int'(cfg_set_bits);
      ways_eff = (cfg_ways == 0) ? 1 : ((cfg_ways > MAX_W) ? MAX_W : int'(cfg_ways));
      shift_t  = int'(cfg_block_bits) + sb_eff;
      tag_pool.delete();
      repeat (ways_eff + $urandom_range(0, 4)) tag_pool.push_back({$urandom, $urandom});
      item_count = (phase == 0) ? 60 : 85;

      // Mostly addresses built from a small tag pool and few sets, so hits and
      // evictions are common; the rest are fully random addresses.
      repeat (item_count) begin
        addr = {$urandom, $urandom};
        if ($urandom_range(0, 7) != 0) begin
          addr &= (64'd1 << cfg_block_bits) - 1;
          set_pick = $urandom_range(0, (1 << sb_eff) - 1);
          if ($urandom_range(0, 3) != 0) set_pick &= 3;
          addr |= 64'(set_pick) << cfg_block_bits;
          if (shift_t < 64)
            addr |= tag_pool[$urandom_range(0, tag_pool.size() - 1)] << shift_t;
        end
        acc.action  = 2'($urandom_range(0, 3));
        acc.address = addr;
        pending_requests.push_back(acc);
      end
      wait_drained();
      repeat (4) @(posedge clk);
    end

    repeat (20) @(posedge clk);
    $display("checked %0d results over %0d phases and %0d register writes", results_checked,
             PHASES, config_writes);
    $display("outcomes seen: %0d hits, %0d fills, %0d evictions", outcome_seen[OUT_HIT],
             outcome_seen[OUT_FILL], outcome_seen[OUT_EVICT]);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches,
               expected_results.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
